// ===== sv/alpt_pkg.sv =====
// ----------------------------------------------------------------------------
// alpt_pkg
// shared types, codes and sizes of the asymmetric link peer table
// ----------------------------------------------------------------------------
`default_nettype none

package alpt_pkg;

  localparam int PEER_SLOTS  = 16;
  localparam int SLOT_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(PEER_SLOTS + 1);
  localparam int MAX_REPORTS = 16;
  localparam int REP_W       = 5;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 32;

  typedef enum logic [1:0] {
    MODE_TX   = 2'd0,
    MODE_RX   = 2'd1,
    MODE_EVAL = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REC  = 2'd0,
    KIND_FLAG = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  localparam logic [CFG_AW-1:0] CFG_TX_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RATIO        = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WINDOW_MS    = 2'd2;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] peer_id;
    logic [62:0] now_ms;
    logic [4:0]  report_cap;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] flagged_id;
    logic [4:0]  reported;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] id;
    logic [62:0] first;
    logic [31:0] tx;
    logic [31:0] rx;
  } entry_t;

  typedef enum logic [1:0] {
    OUT_REC,
    OUT_PEND_MORE,
    OUT_PEND_LAST,
    OUT_NONE
  } out_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LK_RD,
    ST_LK_CHK,
    ST_OLD_RD,
    ST_OLD_CHK,
    ST_TOP_RD,
    ST_MOVE,
    ST_APPEND,
    ST_EV_RD,
    ST_EV_CHK,
    ST_EV_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     latch;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_en;
    logic     rd_top;
    logic     old_upd;
    logic     wr_bump;
    logic     wr_move;
    logic     wr_append;
    logic     ev_take;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  id_match;
    logic  used_zero;
    logic  used_full;
    logic  cap_zero;
    logic  idx_at_last;
    logic  idx_at_top;
    logic  eval_hit;
    logic  take_fills_cap;
    logic  pend_v;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/alpt_dp.sv =====
// ----------------------------------------------------------------------------
// alpt_dp
// datapath: config registers, slot memory, scan index, eviction and report
// ----------------------------------------------------------------------------
`default_nettype none

module alpt_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [alpt_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [alpt_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire alpt_pkg::in_t               in_data,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output alpt_pkg::out_t                   out_data,
  input  wire alpt_pkg::cmd_t              cmd,
  output alpt_pkg::sts_t                   sts
);

  localparam logic [alpt_pkg::SLOT_W-1:0] TOP = alpt_pkg::SLOT_W'(alpt_pkg::PEER_SLOTS - 1);

  logic [31:0]                  thr_r;
  logic [15:0]                  ratio_r;
  logic [31:0]                  win_r;
  alpt_pkg::in_t                item_r;
  logic [alpt_pkg::SLOT_W-1:0]  idx_r;
  logic [alpt_pkg::CNT_W-1:0]   used_r;
  logic [alpt_pkg::SLOT_W-1:0]  old_idx_r;
  logic [62:0]                  old_time_r;
  logic [alpt_pkg::REP_W-1:0]   n_r;
  logic                         pend_v_r;
  logic [63:0]                  pend_id_r;
  logic [alpt_pkg::REP_W-1:0]   pend_n_r;
  logic                         out_v_r;
  alpt_pkg::out_t               out_r;
  alpt_pkg::entry_t             rd_q_r;
  alpt_pkg::entry_t             mem [alpt_pkg::PEER_SLOTS];

  logic [alpt_pkg::REP_W-1:0]   cap_eff;
  logic [63:0]                  age;
  logic [47:0]                  prod;
  logic                         out_free;
  alpt_pkg::entry_t             bump_e;
  alpt_pkg::entry_t             new_e;
  alpt_pkg::entry_t             wr_data;
  logic [alpt_pkg::SLOT_W-1:0]  wr_addr;
  logic                         wr_en;
  logic [alpt_pkg::SLOT_W-1:0]  rd_addr;
  alpt_pkg::out_t               out_nxt;

  assign cap_eff = (item_r.report_cap > alpt_pkg::REP_W'(alpt_pkg::MAX_REPORTS))
                   ? alpt_pkg::REP_W'(alpt_pkg::MAX_REPORTS) : item_r.report_cap;
  assign age  = {1'b0, item_r.now_ms} - {1'b0, rd_q_r.first};
  assign prod = rd_q_r.rx * ratio_r;
  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    bump_e = rd_q_r;
    if (item_r.mode == alpt_pkg::MODE_TX) begin
      if (rd_q_r.tx != 32'hFFFF_FFFF) bump_e.tx = rd_q_r.tx + 32'd1;
    end else begin
      if (rd_q_r.rx != 32'hFFFF_FFFF) bump_e.rx = rd_q_r.rx + 32'd1;
    end
    new_e.id    = item_r.peer_id;
    new_e.first = item_r.now_ms;
    new_e.tx    = (item_r.mode == alpt_pkg::MODE_TX) ? 32'd1 : 32'd0;
    new_e.rx    = (item_r.mode == alpt_pkg::MODE_RX) ? 32'd1 : 32'd0;
  end

  always_comb begin
    wr_en   = cmd.wr_bump || cmd.wr_move || cmd.wr_append;
    wr_addr = idx_r;
    wr_data = bump_e;
    priority if (cmd.wr_move) begin
      wr_addr = old_idx_r;
      wr_data = rd_q_r;
    end else if (cmd.wr_append) begin
      wr_addr = used_r[alpt_pkg::SLOT_W-1:0];
      wr_data = new_e;
    end else begin
      wr_addr = idx_r;
      wr_data = bump_e;
    end
    rd_addr = cmd.rd_top ? TOP : idx_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    out_nxt = '0;
    unique case (cmd.out_sel)
      alpt_pkg::OUT_REC: begin
        out_nxt.kind = alpt_pkg::KIND_REC;
        out_nxt.last = 1'b1;
      end
      alpt_pkg::OUT_PEND_MORE: begin
        out_nxt.kind       = alpt_pkg::KIND_FLAG;
        out_nxt.flagged_id = pend_id_r;
        out_nxt.reported   = pend_n_r;
      end
      alpt_pkg::OUT_PEND_LAST: begin
        out_nxt.kind       = alpt_pkg::KIND_FLAG;
        out_nxt.flagged_id = pend_id_r;
        out_nxt.reported   = pend_n_r;
        out_nxt.last       = 1'b1;
      end
      alpt_pkg::OUT_NONE: begin
        out_nxt.kind = alpt_pkg::KIND_NONE;
        out_nxt.last = 1'b1;
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 32'd10;
      ratio_r  <= 16'd4;
      win_r    <= 32'd300000;
      used_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == alpt_pkg::CFG_TX_THRESHOLD) thr_r <= cfg_wdata;
        if (cfg_addr == alpt_pkg::CFG_RATIO) ratio_r <= cfg_wdata[15:0];
        if (cfg_addr == alpt_pkg::CFG_WINDOW_MS) win_r <= cfg_wdata;
      end
      // eviction drops the count to one below full before the append
      if (cmd.wr_move) used_r <= alpt_pkg::CNT_W'(alpt_pkg::PEER_SLOTS - 1);
      else if (cmd.wr_append) used_r <= used_r + 1'b1;
      if (cmd.latch) pend_v_r <= 1'b0;
      else if (cmd.ev_take) pend_v_r <= 1'b1;
      if (cmd.out_load) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
      n_r    <= '0;
    end
    if (cmd.latch || cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.old_upd && (idx_r == '0 || rd_q_r.first < old_time_r)) begin
      old_idx_r  <= idx_r;
      old_time_r <= rd_q_r.first;
    end
    if (cmd.ev_take) begin
      pend_id_r <= rd_q_r.id;
      pend_n_r  <= n_r + 1'b1;
      n_r       <= n_r + 1'b1;
    end
    if (cmd.out_load) out_r <= out_nxt;
  end

  always_comb begin
    sts.mode           = item_r.mode;
    sts.id_match       = rd_q_r.id == item_r.peer_id;
    sts.used_zero      = used_r == '0;
    sts.used_full      = used_r == alpt_pkg::CNT_W'(alpt_pkg::PEER_SLOTS);
    sts.cap_zero       = cap_eff == '0;
    sts.idx_at_last    = (alpt_pkg::CNT_W'(idx_r) + 1'b1) == used_r;
    sts.idx_at_top     = idx_r == TOP;
    sts.eval_hit       = (age >= {32'd0, win_r}) && (rd_q_r.tx >= thr_r)
                         && (prod < {16'd0, rd_q_r.tx});
    sts.take_fills_cap = (n_r + 1'b1) == cap_eff;
    sts.pend_v         = pend_v_r;
    sts.out_free       = out_free;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sv/alpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// alpt_ctrl
// controller: sequences lookup, eviction, append and evaluation scans
// ----------------------------------------------------------------------------
`default_nettype none

module alpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire alpt_pkg::sts_t  sts,
  output alpt_pkg::cmd_t       cmd
);

  alpt_pkg::state_t state_r, state_nxt;
  logic             ev_block;

  // a new hit needs the pending slot, which needs the output register
  assign ev_block = sts.eval_hit && sts.pend_v && !sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= alpt_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alpt_pkg::ST_IDLE:  if (in_valid) state_nxt = alpt_pkg::ST_START;
      alpt_pkg::ST_START: begin
        unique case (sts.mode)
          alpt_pkg::MODE_TX, alpt_pkg::MODE_RX:
            state_nxt = sts.used_zero ? alpt_pkg::ST_APPEND : alpt_pkg::ST_LK_RD;
          alpt_pkg::MODE_EVAL:
            state_nxt = (sts.used_zero || sts.cap_zero) ? alpt_pkg::ST_EV_END
                                                        : alpt_pkg::ST_EV_RD;
          default: state_nxt = alpt_pkg::ST_DONE;
        endcase
      end
      alpt_pkg::ST_LK_RD: state_nxt = alpt_pkg::ST_LK_CHK;
      alpt_pkg::ST_LK_CHK: begin
        priority if (sts.id_match) state_nxt = alpt_pkg::ST_DONE;
        else if (!sts.idx_at_last) state_nxt = alpt_pkg::ST_LK_RD;
        else if (sts.used_full) state_nxt = alpt_pkg::ST_OLD_RD;
        else state_nxt = alpt_pkg::ST_APPEND;
      end
      alpt_pkg::ST_OLD_RD:  state_nxt = alpt_pkg::ST_OLD_CHK;
      alpt_pkg::ST_OLD_CHK:
        state_nxt = sts.idx_at_top ? alpt_pkg::ST_TOP_RD : alpt_pkg::ST_OLD_RD;
      alpt_pkg::ST_TOP_RD:  state_nxt = alpt_pkg::ST_MOVE;
      alpt_pkg::ST_MOVE:    state_nxt = alpt_pkg::ST_APPEND;
      alpt_pkg::ST_APPEND:  state_nxt = alpt_pkg::ST_DONE;
      alpt_pkg::ST_EV_RD:   state_nxt = alpt_pkg::ST_EV_CHK;
      alpt_pkg::ST_EV_CHK: begin
        priority if (ev_block) state_nxt = alpt_pkg::ST_EV_CHK;
        else if ((sts.eval_hit && sts.take_fills_cap) || sts.idx_at_last)
          state_nxt = alpt_pkg::ST_EV_END;
        else state_nxt = alpt_pkg::ST_EV_RD;
      end
      alpt_pkg::ST_EV_END:  if (sts.out_free) state_nxt = alpt_pkg::ST_IDLE;
      alpt_pkg::ST_DONE:    if (sts.out_free) state_nxt = alpt_pkg::ST_IDLE;
      default:              state_nxt = alpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.out_sel = alpt_pkg::OUT_REC;
    in_stall = state_r != alpt_pkg::ST_IDLE;
    unique case (state_r)
      alpt_pkg::ST_IDLE:  cmd.latch = in_valid;
      alpt_pkg::ST_START: ;
      alpt_pkg::ST_LK_RD: cmd.rd_en = 1'b1;
      alpt_pkg::ST_LK_CHK: begin
        priority if (sts.id_match) cmd.wr_bump = 1'b1;
        else if (!sts.idx_at_last) cmd.idx_inc = 1'b1;
        else cmd.idx_clr = 1'b1;
      end
      alpt_pkg::ST_OLD_RD: cmd.rd_en = 1'b1;
      alpt_pkg::ST_OLD_CHK: begin
        cmd.old_upd = 1'b1;
        cmd.idx_inc = !sts.idx_at_top;
      end
      alpt_pkg::ST_TOP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_top = 1'b1;
      end
      alpt_pkg::ST_MOVE:   cmd.wr_move = 1'b1;
      alpt_pkg::ST_APPEND: cmd.wr_append = 1'b1;
      alpt_pkg::ST_EV_RD:  cmd.rd_en = 1'b1;
      alpt_pkg::ST_EV_CHK: begin
        if (!ev_block) begin
          cmd.ev_take  = sts.eval_hit;
          cmd.out_load = sts.eval_hit && sts.pend_v;
          cmd.out_sel  = alpt_pkg::OUT_PEND_MORE;
          cmd.idx_inc  = !((sts.eval_hit && sts.take_fills_cap) || sts.idx_at_last);
        end
      end
      alpt_pkg::ST_EV_END: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = sts.pend_v ? alpt_pkg::OUT_PEND_LAST : alpt_pkg::OUT_NONE;
      end
      alpt_pkg::ST_DONE: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = alpt_pkg::OUT_REC;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/asymmetric_link_peer_table.sv =====
// ----------------------------------------------------------------------------
// asymmetric_link_peer_table
// peer table with saturating tx/rx counters, oldest-first eviction and
// an evaluation scan that reports asymmetric peers
// ----------------------------------------------------------------------------
//   port group  direction  handshake        word
//   in_*        input      in_valid/stall   in_t: mode, peer_id, now_ms, cap
//   out_*       output     out_valid/stall  out_t: kind, id, reported, last
//   cfg_*       input      cfg_we           index cfg_addr, data cfg_wdata
//
// one word at a time; each slot visit is a read plus a check on the single
// registered read port of the slot memory
// record: lookup scan, then append if absent; a full table first evicts the oldest
// evaluate: scan of filled slots up to the report cap, plus any wait on out_stall
// reset sets config, fill count, flags, state; slot contents are written before use
`default_nettype none

module asymmetric_link_peer_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire alpt_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output alpt_pkg::out_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [alpt_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [alpt_pkg::CFG_DW-1:0] cfg_wdata
);

  alpt_pkg::cmd_t cmd;
  alpt_pkg::sts_t sts;

  alpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  alpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while another is in work");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_append |-> !sts.used_full)
    else $error("append into a full table");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrites a waiting word");

  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ev_take |-> (!sts.pend_v || sts.out_free))
    else $error("pending report lost");

endmodule

`default_nettype wire
